[rtl/pld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pld_pkg: shared types and constants for the padded logical path decoder
// Segment type codes, the parser phase encoding and the result record.
// ----------------------------------------------------------------------------
package pld_pkg;

   localparam int ByteWidth  = 8;
   localparam int IdentWidth = 16;
   localparam int WordsWidth = 9;
   localparam int CountWidth = 10;
   localparam int RspDataWidth = 64;

   // Logical segment type codes (8-bit and 16-bit formats)
   localparam logic [ByteWidth-1:0] SEG_CLASS_8  = 8'h20;
   localparam logic [ByteWidth-1:0] SEG_CLASS_16 = 8'h21;
   localparam logic [ByteWidth-1:0] SEG_INST_8   = 8'h24;
   localparam logic [ByteWidth-1:0] SEG_INST_16  = 8'h25;
   localparam logic [ByteWidth-1:0] SEG_ATTR_8   = 8'h30;
   localparam logic [ByteWidth-1:0] SEG_ATTR_16  = 8'h31;

   // Top three bits set marks a reserved segment type
   localparam logic [2:0] SEG_RESERVED_TOP = 3'b111;

   // Parser phase, one-hot
   typedef enum logic [5:0] {
      PH_SIZE = 6'b000001,
      PH_TYPE = 6'b000010,
      PH_VAL8 = 6'b000100,
      PH_PAD  = 6'b001000,
      PH_LOW  = 6'b010000,
      PH_HIGH = 6'b100000
   } phase_type;

   // Which identifier a segment writes
   typedef enum logic [1:0] {
      TGT_CLASS = 2'd0,
      TGT_INST  = 2'd1,
      TGT_ATTR  = 2'd2
   } target_type;

   // One result beat
   typedef struct packed {
      logic [IdentWidth-1:0] class_ident;
      logic [IdentWidth-1:0] instance_ident;
      logic [IdentWidth-1:0] attribute_ident;
      logic                  bad_path;
      logic [CountWidth-1:0] bytes_consumed;
   } result_type;

endpackage
`default_nettype wire

[rtl/padded_logical_path_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// padded_logical_path_decoder: byte-wide padded logical path parser
// Decodes class, instance and attribute logical segments of a padded path.
// ----------------------------------------------------------------------------
// The block takes one path byte per clock, size byte first, and issues one
// result beat for each path: the three identifiers and the bytes consumed, or
// an error flag (tuser) for a reserved or unknown segment type. A byte's effect
// on the parser state is settled in the cycle it is accepted, so throughput is
// one byte per cycle; a path's result beat shows on the rsp side in the cycle
// after its last byte if the output register is free or drains then, else it
// waits in the skid register. This two-entry buffer (output register plus skid
// register) lets input bytes flow on while a result waits; req_tready drops only while both entries are full.
module padded_logical_path_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] path_byte
   // response stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [15:0] class_ident, [31:16] instance_ident,
                                         // [47:32] attribute_ident,
                                         // [57:48] bytes_consumed, [63:58] zero
   output      logic        rsp_tuser    // [0] bad_path
);
   import pld_pkg::*;

   // parser state
   phase_type             phase_ff, phase_in;
   logic [ByteWidth-1:0]  size_ff, size_in;
   logic [WordsWidth-1:0] words_ff, words_in;
   target_type            target_ff, target_in;
   logic [ByteWidth-1:0]  low_ff, low_in;
   logic [IdentWidth-1:0] class_ff, class_in;
   logic [IdentWidth-1:0] inst_ff, inst_in;
   logic [IdentWidth-1:0] attr_ff, attr_in;

   // output buffer
   logic       main_valid_ff, main_valid_in;
   result_type main_ff, main_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic                  accept;
   logic                  emit;
   logic                  check;
   logic                  bad;
   logic                  store;
   logic [IdentWidth-1:0] store_val;
   result_type            res;
   logic                  pop;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // next parser state for the byte on req_tdata
   always_comb begin
      phase_in  = phase_ff;
      size_in   = size_ff;
      words_in  = words_ff;
      target_in = target_ff;
      low_in    = low_ff;
      class_in  = class_ff;
      inst_in   = inst_ff;
      attr_in   = attr_ff;
      check     = 1'b0;
      bad       = 1'b0;
      store     = 1'b0;
      store_val = '0;
      case (phase_ff)
         PH_SIZE: begin
            size_in  = req_tdata;
            words_in = '0;
            class_in = '0;
            inst_in  = '0;
            attr_in  = '0;
            check    = 1'b1;
         end
         PH_TYPE: begin
            if (req_tdata[7:5] == SEG_RESERVED_TOP) begin
               bad = 1'b1;
            end else begin
               case (req_tdata)
                  SEG_CLASS_8:  begin target_in = TGT_CLASS; phase_in = PH_VAL8; end
                  SEG_INST_8:   begin target_in = TGT_INST;  phase_in = PH_VAL8; end
                  SEG_ATTR_8:   begin target_in = TGT_ATTR;  phase_in = PH_VAL8; end
                  SEG_CLASS_16: begin target_in = TGT_CLASS; phase_in = PH_PAD;  end
                  SEG_INST_16:  begin target_in = TGT_INST;  phase_in = PH_PAD;  end
                  SEG_ATTR_16:  begin target_in = TGT_ATTR;  phase_in = PH_PAD;  end
                  default:      bad = 1'b1;
               endcase
            end
         end
         PH_VAL8: begin
            store     = 1'b1;
            store_val = {{(IdentWidth-ByteWidth){1'b0}}, req_tdata};
            words_in  = words_ff + WordsWidth'(1);
            check     = 1'b1;
         end
         PH_PAD:  phase_in = PH_LOW;
         PH_LOW: begin
            low_in   = req_tdata;
            phase_in = PH_HIGH;
         end
         PH_HIGH: begin
            store     = 1'b1;
            store_val = {req_tdata, low_ff};
            words_in  = words_ff + WordsWidth'(2);
            check     = 1'b1;
         end
         default: phase_in = PH_SIZE;
      endcase

      // identifier write
      if (store) begin
         case (target_ff)
            TGT_CLASS: class_in = store_val;
            TGT_INST:  inst_in  = store_val;
            default:   attr_in  = store_val;
         endcase
      end

      // end of path or abort
      emit = bad || (check && (words_in >= {1'b0, size_in}));
      if (emit) begin
         phase_in = PH_SIZE;
      end else if (check) begin
         phase_in = PH_TYPE;
      end
   end

   // result record
   always_comb begin
      res = '0;
      if (bad) begin
         res.bad_path = 1'b1;
      end else begin
         res.class_ident     = class_in;
         res.instance_ident  = inst_in;
         res.attribute_ident = attr_in;
         res.bytes_consumed  = {words_in, 1'b1};
      end
   end

   // output register and skid register
   assign pop = main_valid_ff && rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && emit) begin
         if (!main_valid_ff || pop) begin
            main_in       = res;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         size_ff       <= '0;
         words_ff      <= '0;
         target_ff     <= TGT_CLASS;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            size_ff   <= size_in;
            words_ff  <= words_in;
            target_ff <= target_in;
         end
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         low_ff   <= low_in;
         class_ff <= class_in;
         inst_ff  <= inst_in;
         attr_ff  <= attr_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tuser  = main_ff.bad_path;
   assign rsp_tdata  = {{(RspDataWidth-3*IdentWidth-CountWidth){1'b0}},
                        main_ff.bytes_consumed, main_ff.attribute_ident,
                        main_ff.instance_ident, main_ff.class_ident};

   // checks
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without output entry");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("error beat carries nonzero payload");

   a_ok_count_odd: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tdata[48])
      else $error("bytes_consumed of a good path must be odd");

   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> (phase_ff == PH_SIZE))
      else $error("parser did not return to size byte after a result");

endmodule
`default_nettype wire

[test/padded_logical_path_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_logical_path_decoder_test: self-checking bench for the path decoder
// Streams padded logical paths byte by byte into the decoder. This includes
// well-formed paths, paths aborted by bad segment types and stray bytes. A
// bit-level model of the parser predicts each result beat. Results are
// checked in order, field by field, under random stalls on both sides.
// ----------------------------------------------------------------------------
module padded_logical_path_decoder_test;
   import pld_pkg::*;

   localparam int StimBytes  = 1300;
   localparam int IdleLimit  = 2000;   // cycles without any beat before giving up
   localparam int LongHold   = 400;    // receiver stall to back up the decoder
   localparam int HoldAtRsp  = 60;     // results seen before the long stall
   localparam int TailCycles = 20;

   // one entry of the byte feed; a drain entry makes the sender wait for results
   typedef struct {
      logic [7:0] value;
      bit         drain;
   } path_beat_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;

   padded_logical_path_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   path_beat_type path_feed[$];
   result_type decoded_paths[$];

   // parser model state
   phase_type       mdl_phase  = PH_SIZE;
   logic [7:0]      mdl_size   = '0;
   logic [8:0]      mdl_words  = '0;
   target_type      mdl_target = TGT_CLASS;
   logic [7:0]      mdl_low    = '0;
   logic [15:0]     mdl_class  = '0;
   logic [15:0]     mdl_inst   = '0;
   logic [15:0]     mdl_attr   = '0;

   // handshake flags sampled at the rising edge, read at the falling edge
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;

   int stim_bytes     = 0;
   int bytes_accepted = 0;
   int results_seen   = 0;
   int bad_seen       = 0;
   int max_consumed   = 0;
   int errors         = 0;
   bit draining       = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Parser model: consume one path byte, queue the result it completes
   // ------------------------------------------------------------------------
   function automatic void store_ident(input logic [15:0] id);
      case (mdl_target)
         TGT_CLASS: mdl_class = id;
         TGT_INST:  mdl_inst  = id;
         default:   mdl_attr  = id;
      endcase
   endfunction

   task automatic decode_path_byte(input logic [7:0] b);
      result_type r;
      bit         check;
      bit         bad;
      r     = '0;
      check = 1'b0;
      bad   = 1'b0;
      case (mdl_phase)
         PH_SIZE: begin
            mdl_size  = b;
            mdl_words = '0;
            mdl_class = '0;
            mdl_inst  = '0;
            mdl_attr  = '0;
            check     = 1'b1;
         end
         PH_TYPE: begin
            if (b[7:5] == SEG_RESERVED_TOP) begin
               bad = 1'b1;
            end else begin
               case (b)
                  SEG_CLASS_8:  begin mdl_target = TGT_CLASS; mdl_phase = PH_VAL8; end
                  SEG_INST_8:   begin mdl_target = TGT_INST;  mdl_phase = PH_VAL8; end
                  SEG_ATTR_8:   begin mdl_target = TGT_ATTR;  mdl_phase = PH_VAL8; end
                  SEG_CLASS_16: begin mdl_target = TGT_CLASS; mdl_phase = PH_PAD;  end
                  SEG_INST_16:  begin mdl_target = TGT_INST;  mdl_phase = PH_PAD;  end
                  SEG_ATTR_16:  begin mdl_target = TGT_ATTR;  mdl_phase = PH_PAD;  end
                  default:      bad = 1'b1;
               endcase
            end
         end
         PH_VAL8: begin
            store_ident({8'h00, b});
            mdl_words = mdl_words + 9'd1;
            check     = 1'b1;
         end
         PH_PAD: begin
            mdl_phase = PH_LOW;   // pad value ignored
         end
         PH_LOW: begin
            mdl_low   = b;
            mdl_phase = PH_HIGH;
         end
         PH_HIGH: begin
            store_ident({b, mdl_low});
            mdl_words = mdl_words + 9'd2;
            check     = 1'b1;
         end
         default: mdl_phase = PH_SIZE;
      endcase

      if (bad) begin
         r.bad_path = 1'b1;
         mdl_phase  = PH_SIZE;
         decoded_paths.push_back(r);
      end else if (check) begin
         if (mdl_words >= {1'b0, mdl_size}) begin
            r.class_ident     = mdl_class;
            r.instance_ident  = mdl_inst;
            r.attribute_ident = mdl_attr;
            r.bytes_consumed  = {mdl_words, 1'b1};
            mdl_phase         = PH_SIZE;
            decoded_paths.push_back(r);
         end else begin
            mdl_phase = PH_TYPE;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [7:0] rand_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_byte(input logic [7:0] b);
      path_beat_type e;
      e.value = b;
      e.drain = 1'b0;
      path_feed.push_back(e);
      stim_bytes++;
   endtask

   task automatic push_drain();
      path_beat_type e;
      e.value = 8'h00;
      e.drain = 1'b1;
      path_feed.push_back(e);
   endtask

   task automatic add_segment(input int field, input bit wide, output int words);
      logic [7:0] code;
      case (field)
         0:       code = wide ? SEG_CLASS_16 : SEG_CLASS_8;
         1:       code = wide ? SEG_INST_16  : SEG_INST_8;
         default: code = wide ? SEG_ATTR_16  : SEG_ATTR_8;
      endcase
      push_byte(code);
      if (wide) begin
         push_byte(rand_byte());   // pad
         push_byte(rand_byte());
         push_byte(rand_byte());
         words = 2;
      end else begin
         push_byte(rand_byte());
         words = 1;
      end
   endtask

   task automatic add_good_path(input int size);
      int done;
      int w;
      done = 0;
      push_byte(8'(size));
      while (done < size) begin
         add_segment($urandom_range(0, 2), 1'($urandom_range(0, 1)), w);
         done += w;
      end
   endtask

   // bad segment type: reserved (top three bits set) or simply unknown
   function automatic logic [7:0] bad_type_byte();
      logic [7:0] b;
      if ($urandom_range(0, 1) == 0)
         return {SEG_RESERVED_TOP, 5'($urandom_range(0, 31))};
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b[7:5] == SEG_RESERVED_TOP || b == SEG_CLASS_8 || b == SEG_CLASS_16 ||
                 b == SEG_INST_8 || b == SEG_INST_16 || b == SEG_ATTR_8 ||
                 b == SEG_ATTR_16);
      return b;
   endfunction

   // ------------------------------------------------------------------------
   // Reset, stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      logic [7:0] directed[];
      int         pick;
      int         size;
      int         nseg;
      int         w;
      bit         drained_mid;

      reset = 1'b1;
      drained_mid = 1'b0;

      // directed paths
      directed = '{
         8'h00,                                              // empty path
         8'h01, SEG_CLASS_8, 8'hFF,                          // 8-bit class
         8'h02, SEG_INST_16, 8'hAA, 8'h34, 8'h12,            // 16-bit instance
         8'h01, SEG_ATTR_16, 8'h55, 8'hFF, 8'hFF,            // overshoot by one word
         8'h03, SEG_CLASS_8, 8'h11, SEG_CLASS_8, 8'h22,      // repeated class
         SEG_ATTR_8, 8'h00,
         8'h02, 8'hE0,                                       // reserved type
         8'h05, 8'hFF,                                       // reserved type
         8'h01, 8'h00                                        // unknown type
      };
      foreach (directed[i]) push_byte(directed[i]);
      push_drain();

      // largest path that overshoots: 256 words, 513 bytes consumed
      push_byte(8'hFF);
      for (int i = 0; i < 128; i++) add_segment($urandom_range(0, 2), 1'b1, w);

      // random part: mostly well-formed paths, some aborted, some stray bytes
      while (stim_bytes < StimBytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            if ($urandom_range(0, 59) == 0) size = $urandom_range(32, 255);
            else size = $urandom_range(0, 9);
            add_good_path(size);
         end else if (pick < 95) begin
            size = $urandom_range(1, 10);
            nseg = $urandom_range(0, 2);
            if (nseg >= size) nseg = size - 1;
            push_byte(8'(size));
            for (int i = 0; i < nseg; i++) add_segment($urandom_range(0, 2), 1'b0, w);
            push_byte(bad_type_byte());
         end else begin
            nseg = $urandom_range(1, 4);
            for (int i = 0; i < nseg; i++) push_byte(8'($urandom_range(0, 255)));
         end
         if (!drained_mid && stim_bytes > 900) begin
            push_drain();
            drained_mid = 1'b1;
         end
      end

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // wait for the feed and all expected results
      while (path_feed.size() != 0 || req_tvalid || draining || decoded_paths.size() != 0)
         @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      $display("Run covered %0d path bytes and %0d result beats (%0d aborted paths).",
               bytes_accepted, results_seen, bad_seen);
      $display("Largest bytes consumed reported: %0d.", max_consumed);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sender: drives the next path byte at the falling edge
   // ------------------------------------------------------------------------
   int req_gap  = 0;
   int req_calm = 0;

   always @(negedge clock) begin
      path_beat_type e;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // new idle draw for each beat taken
         if (req_fire) begin
            if (req_calm > 0) begin
               req_gap = 0;
               req_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
               req_gap  = 0;
               req_calm = $urandom_range(20, 60);
            end else begin
               req_gap = $urandom_range(0, 11);
            end
         end

         if (req_tvalid && !req_fire) begin
            // beat still waiting for ready
         end else if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (draining) begin
            req_tvalid <= 1'b0;
            if (decoded_paths.size() == 0) draining = 1'b0;
         end else if (path_feed.size() != 0) begin
            e = path_feed.pop_front();
            if (e.drain) begin
               req_tvalid <= 1'b0;
               draining = 1'b1;
            end else begin
               req_tdata  <= e.value;
               req_tvalid <= 1'b1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random ready with one long stall
   // ------------------------------------------------------------------------
   int rsp_gap   = 0;
   int rsp_calm  = 0;
   int rsp_hold  = 0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if (rsp_calm > 0) begin
               rsp_gap = 0;
               rsp_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
               rsp_gap  = 0;
               rsp_calm = $urandom_range(20, 60);
            end else begin
               rsp_gap = $urandom_range(0, 11);
            end
         end
         if (!hold_done && results_seen >= HoldAtRsp) begin
            rsp_hold  = LongHold;
            hold_done = 1'b1;
         end

         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitors: predict on each accepted byte, check each result beat
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type exp_r;
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            decode_path_byte(req_tdata);
            bytes_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tuser) bad_seen++;
            if (decoded_paths.size() == 0) begin
               $error("result beat with no decoded path pending: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               exp_r = decoded_paths.pop_front();
               if (rsp_tdata[15:0] !== exp_r.class_ident) begin
                  $error("class_ident: expected %h, got %h", exp_r.class_ident,
                         rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[31:16] !== exp_r.instance_ident) begin
                  $error("instance_ident: expected %h, got %h", exp_r.instance_ident,
                         rsp_tdata[31:16]);
                  errors++;
               end
               if (rsp_tdata[47:32] !== exp_r.attribute_ident) begin
                  $error("attribute_ident: expected %h, got %h", exp_r.attribute_ident,
                         rsp_tdata[47:32]);
                  errors++;
               end
               if (rsp_tuser !== exp_r.bad_path) begin
                  $error("bad_path: expected %b, got %b", exp_r.bad_path, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[57:48] !== exp_r.bytes_consumed) begin
                  $error("bytes_consumed: expected %0d, got %0d", exp_r.bytes_consumed,
                         rsp_tdata[57:48]);
                  errors++;
               end
               if (!exp_r.bad_path && int'(exp_r.bytes_consumed) > max_consumed)
                  max_consumed = int'(exp_r.bytes_consumed);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long without any beat on either side
   // ------------------------------------------------------------------------
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no beat for %0d cycles", IdleLimit);
      $display("Mismatches found");
      $finish;
   end

endmodule
